>>> sv/gcu_pkg.sv
// ----------------------------------------------------------------------------
// gcu_pkg
// shared types, constants, activation tables and saturation helpers for the
// gated recurrent cell unit step core
// ----------------------------------------------------------------------------
package gcu_pkg;

    localparam int DEF_INPUT_LEN = 64;
    localparam int DEF_UNITS     = 64;

    localparam int FRAC_BITS = 12;
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int DATA_W    = 16;
    localparam int PROD_W    = 33 - FRAC_BITS;
    localparam int ACC_W     = PROD_W + 9;

    typedef enum logic [2:0] {
        CMD_INPUT     = 3'd0,
        CMD_KERNEL    = 3'd1,
        CMD_RECURRENT = 3'd2,
        CMD_BIAS      = 3'd3,
        CMD_RECBIAS   = 3'd4,
        CMD_COMPUTE   = 3'd5,
        CMD_SYNC      = 3'd6,
        CMD_CLEAR     = 3'd7
    } cmd_t;

    typedef struct packed {
        logic clear;
        logic sync;
        logic wr_en;
        logic rd_en;
    } hid_ctrl_t;

    typedef logic signed [DATA_W-1:0] table_t [256];

    // shift and subtract quotient, used only while the tables are built
    function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
        longint unsigned q;
        longint unsigned rem;
        q   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = (rem << 1) | 64'(n[i]);
            if (rem >= d)
            begin
                rem  = rem - d;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic table_t build_table(bit tanh_sel);
        longint unsigned ex [257];
        longint unsigned q30;
        longint unsigned p;
        longint unsigned num;
        longint unsigned den;
        longint unsigned q;
        longint unsigned tden;
        longint unsigned tv;
        longint unsigned sv;
        int k;
        int m;
        table_t t;
        q30   = 64'd1 << 30;
        ex[0] = q30;
        for (int i = 1; i <= 256; i++)
        begin
            ex[i] = (ex[i-1] * 64'd1008687095 + (q30 >> 1)) >> 30;
        end
        for (int i = 0; i < 256; i++)
        begin
            k    = i - 128;
            m    = (k < 0) ? -k : k;
            p    = ex[m];
            num  = (k >= 0) ? q30 : p;
            den  = q30 + p;
            q    = ex[2*m];
            tden = q30 + q;
            sv   = udiv64(num * 64'(ONE) * 64'd2 + den, 64'd2 * den);
            tv   = udiv64((q30 - q) * 64'(ONE) * 64'd2 + tden, 64'd2 * tden);
            if (tanh_sel)
            begin
                t[i] = (k < 0) ? -DATA_W'(tv) : DATA_W'(tv);
            end
            else
            begin
                t[i] = DATA_W'(sv);
            end
        end
        return t;
    endfunction

    localparam table_t SIG_TABLE  = build_table(1'b0);
    localparam table_t TANH_TABLE = build_table(1'b1);

    function automatic logic signed [DATA_W-1:0] sat16(logic signed [ACC_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 32767)
        begin
            r = 16'sh7fff;
        end
        else if (v < -32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = DATA_W'(v);
        end
        return r;
    endfunction

    function automatic logic [7:0] lut_index(logic signed [DATA_W-1:0] x);
        logic signed [20:0] t;
        t = 21'(x) + 21'(8 * ONE);
        if (t < 0)
        begin
            t = '0;
        end
        if (t > 16 * ONE - 1)
        begin
            t = 21'(16 * ONE - 1);
        end
        return 8'(t >>> (FRAC_BITS - 4));
    endfunction

endpackage

>>> sv/gru_cell_unit_step_core.sv
// ----------------------------------------------------------------------------
// gru_cell_unit_step_core
// one hidden unit step of a gated recurrent cell, reset-after form, Q3.12
// ----------------------------------------------------------------------------
// The six gate dot products of a compute walk the weight memories one product
// per cycle through the single shared multiplier, followed by six activation
// and blend steps, three of which use the same multiplier. Sync copies the
// next vector into the current one with a sweep. The input is stalled while
// a command is in progress; a finished word waits in the output register.
module gru_cell_unit_step_core
    import gcu_pkg::*;
#(
    parameter int INPUT_LEN = DEF_INPUT_LEN,
    parameter int UNITS     = DEF_UNITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [2:0]               command,
    input  logic [5:0]               row_index,
    input  logic [7:0]               column_index,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] hidden_out,
    output logic [5:0]               unit_number
);

    localparam int GATE_COLS = 3 * UNITS;
    localparam int IN_AW     = (INPUT_LEN > 1) ? $clog2(INPUT_LEN) : 1;
    localparam int UN_AW     = (UNITS > 1) ? $clog2(UNITS) : 1;
    localparam int IW_DEPTH  = INPUT_LEN * GATE_COLS;
    localparam int RW_DEPTH  = UNITS * GATE_COLS;
    localparam int MAX_DEPTH = (IW_DEPTH > RW_DEPTH) ? IW_DEPTH : RW_DEPTH;
    localparam int MAX_N     = (INPUT_LEN > UNITS) ? INPUT_LEN : UNITS;
    localparam int IW_AW     = $clog2(IW_DEPTH);
    localparam int RW_AW     = $clog2(RW_DEPTH);
    localparam int W_AW      = $clog2(MAX_DEPTH);
    localparam int GC_W      = $clog2(GATE_COLS);
    localparam int CNT_W     = $clog2(MAX_N + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SYNC,
        S_WALK,
        S_DRAIN,
        S_BIAS,
        S_ACT,
        S_RH,
        S_CAND,
        S_ZH,
        S_ZC,
        S_OUT
    } state_t;

    state_t                   state_reg;
    logic                     src_reg;
    logic [1:0]               gate_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [W_AW-1:0]          waddr_reg;
    logic [GC_W-1:0]          col_reg;
    logic [5:0]               unit_reg;
    logic                     rd_v_reg;
    logic                     p_v_reg;
    logic                     out_valid_reg;

    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [DATA_W-1:0] xs_reg [3];
    logic signed [DATA_W-1:0] hs_reg [3];
    logic signed [DATA_W-1:0] z_reg;
    logic signed [DATA_W-1:0] r_reg;
    logic signed [DATA_W-1:0] c_reg;
    logic signed [DATA_W-1:0] hu_reg;
    logic signed [PROD_W-1:0] p1_reg;
    logic signed [DATA_W-1:0] hidden_out_reg;
    logic [5:0]               unit_number_reg;

    logic signed [DATA_W-1:0] iv_mem [INPUT_LEN];
    logic signed [DATA_W-1:0] iw_mem [IW_DEPTH];
    logic signed [DATA_W-1:0] rw_mem [RW_DEPTH];
    logic signed [DATA_W-1:0] ib_mem [GATE_COLS];
    logic signed [DATA_W-1:0] rb_mem [GATE_COLS];
    logic signed [DATA_W-1:0] iv_rd_reg;
    logic signed [DATA_W-1:0] iw_rd_reg;
    logic signed [DATA_W-1:0] rw_rd_reg;
    logic signed [DATA_W-1:0] ib_rd_reg;
    logic signed [DATA_W-1:0] rb_rd_reg;

    logic                     accept;
    cmd_t                     cmd;
    logic                     row_in_ok;
    logic                     row_un_ok;
    logic                     col_ok;
    logic [IW_AW-1:0]         iw_wa;
    logic [RW_AW-1:0]         rw_wa;
    logic                     walk_last;
    logic                     out_free;
    logic signed [DATA_W-1:0] bias_sel;
    logic signed [DATA_W-1:0] h_new;
    logic signed [DATA_W-1:0] mac_a;
    logic signed [DATA_W-1:0] mac_b;
    logic                     mac_en;
    logic signed [PROD_W-1:0] prod;
    hid_ctrl_t                hid_ctrl;
    logic [UN_AW-1:0]         hid_rd_addr;
    logic signed [DATA_W-1:0] hid_rd;
    logic                     hid_busy;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid & ~in_stall;
    assign cmd       = cmd_t'(command);
    assign row_in_ok = int'(row_index) < INPUT_LEN;
    assign row_un_ok = int'(row_index) < UNITS;
    assign col_ok    = int'(column_index) < GATE_COLS;
    assign iw_wa     = IW_AW'(int'(row_index) * GATE_COLS + int'(column_index));
    assign rw_wa     = RW_AW'(int'(row_index) * GATE_COLS + int'(column_index));
    assign walk_last = src_reg ? (cnt_reg == CNT_W'(UNITS - 1))
                               : (cnt_reg == CNT_W'(INPUT_LEN - 1));
    assign out_free  = ~out_valid_reg | ~out_stall;
    assign bias_sel  = src_reg ? rb_rd_reg : ib_rd_reg;
    assign h_new     = sat16(ACC_W'(p1_reg) + ACC_W'(prod));

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            src_reg       <= 1'b0;
            gate_reg      <= '0;
            cnt_reg       <= '0;
            waddr_reg     <= '0;
            col_reg       <= '0;
            unit_reg      <= '0;
            rd_v_reg      <= 1'b0;
            p_v_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg <= (state_reg == S_WALK);
            p_v_reg  <= rd_v_reg;
            if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (cmd)
                            CMD_COMPUTE:
                            begin
                                if (row_un_ok)
                                begin
                                    state_reg <= S_WALK;
                                    src_reg   <= 1'b0;
                                    gate_reg  <= '0;
                                    cnt_reg   <= '0;
                                    col_reg   <= GC_W'(row_index);
                                    waddr_reg <= W_AW'(row_index);
                                    unit_reg  <= row_index;
                                end
                            end
                            CMD_SYNC:
                            begin
                                state_reg <= S_SYNC;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SYNC:
                begin
                    if (!hid_busy)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_WALK:
                begin
                    cnt_reg   <= cnt_reg + 1'b1;
                    waddr_reg <= waddr_reg + W_AW'(GATE_COLS);
                    if (walk_last)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    if (!rd_v_reg && !p_v_reg)
                    begin
                        state_reg <= S_BIAS;
                    end
                end
                S_BIAS:
                begin
                    cnt_reg <= '0;
                    if (!src_reg)
                    begin
                        src_reg   <= 1'b1;
                        waddr_reg <= W_AW'(col_reg);
                        state_reg <= S_WALK;
                    end
                    else if (gate_reg == 2'd2)
                    begin
                        state_reg <= S_ACT;
                    end
                    else
                    begin
                        src_reg   <= 1'b0;
                        gate_reg  <= gate_reg + 1'b1;
                        col_reg   <= col_reg + GC_W'(UNITS);
                        waddr_reg <= W_AW'(col_reg + GC_W'(UNITS));
                        state_reg <= S_WALK;
                    end
                end
                S_ACT:  state_reg <= S_RH;
                S_RH:   state_reg <= S_CAND;
                S_CAND: state_reg <= S_ZH;
                S_ZH:   state_reg <= S_ZC;
                S_ZC:   state_reg <= S_OUT;
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE || state_reg == S_BIAS)
        begin
            acc_reg <= '0;
        end
        else if (p_v_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod);
        end
        if (state_reg == S_BIAS)
        begin
            if (src_reg)
            begin
                hs_reg[gate_reg] <= sat16(acc_reg + ACC_W'(bias_sel));
            end
            else
            begin
                xs_reg[gate_reg] <= sat16(acc_reg + ACC_W'(bias_sel));
            end
        end
        if (state_reg == S_ACT)
        begin
            z_reg <= SIG_TABLE[lut_index(sat16(ACC_W'(xs_reg[0]) + ACC_W'(hs_reg[0])))];
            r_reg <= SIG_TABLE[lut_index(sat16(ACC_W'(xs_reg[1]) + ACC_W'(hs_reg[1])))];
        end
        if (state_reg == S_CAND)
        begin
            c_reg  <= TANH_TABLE[lut_index(sat16(ACC_W'(xs_reg[2]) + ACC_W'(prod)))];
            hu_reg <= hid_rd;
        end
        if (state_reg == S_ZC)
        begin
            p1_reg <= prod;
        end
        if (state_reg == S_OUT && out_free)
        begin
            hidden_out_reg  <= h_new;
            unit_number_reg <= unit_reg;
        end
    end

    // input vector
    always_ff @(posedge clk)
    begin
        if (accept && cmd == CMD_INPUT && row_in_ok)
        begin
            iv_mem[IN_AW'(row_index)] <= value;
        end
        if (state_reg == S_WALK && !src_reg)
        begin
            iv_rd_reg <= iv_mem[cnt_reg[IN_AW-1:0]];
        end
    end

    // input weights
    always_ff @(posedge clk)
    begin
        if (accept && cmd == CMD_KERNEL && row_in_ok && col_ok)
        begin
            iw_mem[iw_wa] <= value;
        end
        if (state_reg == S_WALK && !src_reg)
        begin
            iw_rd_reg <= iw_mem[waddr_reg[IW_AW-1:0]];
        end
    end

    // recurrent weights
    always_ff @(posedge clk)
    begin
        if (accept && cmd == CMD_RECURRENT && row_un_ok && col_ok)
        begin
            rw_mem[rw_wa] <= value;
        end
        if (state_reg == S_WALK && src_reg)
        begin
            rw_rd_reg <= rw_mem[waddr_reg[RW_AW-1:0]];
        end
    end

    // input bias
    always_ff @(posedge clk)
    begin
        if (accept && cmd == CMD_BIAS && col_ok)
        begin
            ib_mem[GC_W'(column_index)] <= value;
        end
        ib_rd_reg <= ib_mem[col_reg];
    end

    // recurrent bias
    always_ff @(posedge clk)
    begin
        if (accept && cmd == CMD_RECBIAS && col_ok)
        begin
            rb_mem[GC_W'(column_index)] <= value;
        end
        rb_rd_reg <= rb_mem[col_reg];
    end

    // operand selection for the shared multiplier
    always_comb
    begin
        mac_a  = src_reg ? hid_rd : iv_rd_reg;
        mac_b  = src_reg ? rw_rd_reg : iw_rd_reg;
        mac_en = rd_v_reg;
        case (state_reg)
            S_RH:
            begin
                mac_a  = r_reg;
                mac_b  = hs_reg[2];
                mac_en = 1'b1;
            end
            S_ZH:
            begin
                mac_a  = z_reg;
                mac_b  = hu_reg;
                mac_en = 1'b1;
            end
            S_ZC:
            begin
                mac_a  = DATA_W'(ONE) - z_reg;
                mac_b  = c_reg;
                mac_en = 1'b1;
            end
            default:
            begin
                mac_en = rd_v_reg;
            end
        endcase
    end

    always_comb
    begin
        hid_ctrl.clear = accept && cmd == CMD_CLEAR;
        hid_ctrl.sync  = accept && cmd == CMD_SYNC;
        hid_ctrl.wr_en = (state_reg == S_OUT) && out_free;
        hid_ctrl.rd_en = (state_reg == S_WALK && src_reg) || (state_reg == S_RH);
        hid_rd_addr    = (state_reg == S_RH) ? UN_AW'(unit_reg) : UN_AW'(cnt_reg);
    end

    gcu_mac u_mac
    (
        .clk  (clk),
        .en   (mac_en),
        .a    (mac_a),
        .b    (mac_b),
        .prod (prod)
    );

    gcu_hidden #(
        .UNITS (UNITS)
    ) u_hidden
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (hid_ctrl),
        .rd_addr (hid_rd_addr),
        .wr_addr (UN_AW'(unit_reg)),
        .wr_data (h_new),
        .rd_data (hid_rd),
        .busy    (hid_busy)
    );

    assign out_valid   = out_valid_reg;
    assign hidden_out  = hidden_out_reg;
    assign unit_number = unit_number_reg;

    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_OUT))
        else $error("output word without finished compute");

    a_idle_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !hid_busy)
        else $error("input open during copy sweep");

    a_bias_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_BIAS |-> !rd_v_reg && !p_v_reg)
        else $error("bias added with products in flight");

    a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK && cnt_reg == '0 |-> acc_reg == '0 && !p_v_reg)
        else $error("accumulator not cleared at walk start");

endmodule

>>> sv/gcu_mac.sv
// ----------------------------------------------------------------------------
// gcu_mac
// shared multiplier with round-half-up rescale and a registered product
// ----------------------------------------------------------------------------
module gcu_mac
    import gcu_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [DATA_W-1:0] a,
    input  logic signed [DATA_W-1:0] b,
    output logic signed [PROD_W-1:0] prod
);

    localparam int HALF = ONE / 2;

    logic signed [31:0] mul;
    logic signed [32:0] rounded;
    logic signed [PROD_W-1:0] prod_reg;

    always_comb
    begin
        mul     = a * b;
        rounded = 33'(mul) + 33'(HALF);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= PROD_W'(rounded >>> FRAC_BITS);
        end
    end

    assign prod = prod_reg;

endmodule

>>> sv/gcu_hidden.sv
// ----------------------------------------------------------------------------
// gcu_hidden
// current and next hidden vectors with valid bits and a copy sweep for sync
// ----------------------------------------------------------------------------
module gcu_hidden
    import gcu_pkg::*;
#(
    parameter int UNITS = DEF_UNITS,
    localparam int AW = (UNITS > 1) ? $clog2(UNITS) : 1
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  hid_ctrl_t                ctrl,
    input  logic [AW-1:0]            rd_addr,
    input  logic [AW-1:0]            wr_addr,
    input  logic signed [DATA_W-1:0] wr_data,
    output logic signed [DATA_W-1:0] rd_data,
    output logic                     busy
);

    logic signed [DATA_W-1:0] cur_mem  [UNITS];
    logic signed [DATA_W-1:0] next_mem [UNITS];
    logic [UNITS-1:0]         cur_valid_reg;
    logic [UNITS-1:0]         next_valid_reg;
    logic                     sweep_active_reg;
    logic                     sweep_wr_reg;
    logic [AW-1:0]            sweep_cnt_reg;
    logic [AW-1:0]            sweep_addr_reg;
    logic signed [DATA_W-1:0] sweep_data_reg;
    logic signed [DATA_W-1:0] rd_raw_reg;
    logic                     rd_ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg    <= '0;
            next_valid_reg   <= '0;
            sweep_active_reg <= 1'b0;
            sweep_wr_reg     <= 1'b0;
            sweep_cnt_reg    <= '0;
        end
        else
        begin
            sweep_wr_reg <= sweep_active_reg;
            if (sweep_active_reg)
            begin
                sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
                if (sweep_cnt_reg == AW'(UNITS - 1))
                begin
                    sweep_active_reg <= 1'b0;
                end
            end
            if (ctrl.clear)
            begin
                cur_valid_reg  <= '0;
                next_valid_reg <= '0;
            end
            else
            begin
                if (ctrl.sync)
                begin
                    cur_valid_reg    <= next_valid_reg;
                    sweep_active_reg <= 1'b1;
                    sweep_cnt_reg    <= '0;
                end
                if (ctrl.wr_en)
                begin
                    next_valid_reg[wr_addr] <= 1'b1;
                end
            end
        end
    end

    // next vector: written by compute, read by the copy sweep
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            next_mem[wr_addr] <= wr_data;
        end
        if (sweep_active_reg)
        begin
            sweep_data_reg <= next_mem[sweep_cnt_reg];
            sweep_addr_reg <= sweep_cnt_reg;
        end
    end

    // current vector: written by the copy sweep, read by compute
    always_ff @(posedge clk)
    begin
        if (sweep_wr_reg)
        begin
            cur_mem[sweep_addr_reg] <= sweep_data_reg;
        end
        if (ctrl.rd_en)
        begin
            rd_raw_reg <= cur_mem[rd_addr];
            rd_ok_reg  <= cur_valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_ok_reg ? rd_raw_reg : '0;
    assign busy    = sweep_active_reg | sweep_wr_reg;

endmodule
